[rtl/core/brm_pkg.sv]
// ----------------------------------------------------------------------------
// brm_pkg: shared types and constants of the bilinear remap engine
// Field widths, opcodes, register indexes and the front-to-back request record.
// ----------------------------------------------------------------------------
`default_nettype none

package brm_pkg;

  // Default sizing of the pixel store and the weight format
  localparam int DEF_STORE_PIXELS     = 65536;
  localparam int DEF_WEIGHT_FRAC_BITS = 14;

  // Fixed field widths
  localparam int IDX_W    = 16;
  localparam int CHAN_W   = 8;
  localparam int PIXEL_W  = 3 * CHAN_W;
  localparam int WEIGHT_W = 15;
  localparam int LW_W     = 13;
  localparam int NUM_NBR  = 4;
  // four products of CHAN_W x WEIGHT_W bits plus the rounding term
  localparam int PROD_W   = CHAN_W + WEIGHT_W;
  localparam int ACC_W    = PROD_W + 3;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LW_W;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THREE_CHANNEL = 1'b1;
  localparam logic [LW_W-1:0]      LINE_WIDTH_RESET  = 13'd640;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_WEIGHTED = 2'd1,
    OP_BOX      = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_e;

  // One classified request handed from the front to the back
  typedef struct packed {
    opcode_e                          op;
    logic [IDX_W-1:0]                 base;
    logic [PIXEL_W-1:0]               pixel;
    logic [NUM_NBR-1:0][WEIGHT_W-1:0] weight;
    logic                             bad;
    logic                             last;
  } req_t;

endpackage

`default_nettype wire

[rtl/core/brm_front.sv]
// ----------------------------------------------------------------------------
// brm_front: request intake and classification
// Accepts input requests, drops those that cause nothing, flags remaps whose
// neighbours run past the store and pushes the rest into the request queue.
// ----------------------------------------------------------------------------
`default_nettype none

module brm_front #(
  parameter int STORE_PIXELS = brm_pkg::DEF_STORE_PIXELS
) (
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic [1:0]                              opcode_i,
  input  wire logic [brm_pkg::IDX_W-1:0]               pixel_index_i,
  input  wire logic [brm_pkg::CHAN_W-1:0]              chan_a_i,
  input  wire logic [brm_pkg::CHAN_W-1:0]              chan_b_i,
  input  wire logic [brm_pkg::CHAN_W-1:0]              chan_c_i,
  input  wire logic [brm_pkg::NUM_NBR-1:0][brm_pkg::WEIGHT_W-1:0] weight_i,
  input  wire logic                                    last_entry_i,
  input  wire logic [brm_pkg::LW_W-1:0]                line_width_i,
  output logic                                         push_o,
  output brm_pkg::req_t                                push_req_o,
  input  wire logic                                    queue_full_i
);
  import brm_pkg::*;

  localparam int AW   = $clog2(STORE_PIXELS);
  localparam int SUMW = (AW > IDX_W + 1) ? AW : IDX_W + 1;

  opcode_e         op;
  logic [SUMW-1:0] far_sum;
  logic            far_bad;
  logic            base_bad;
  logic            keep;

  assign op = opcode_e'(opcode_i);

  // bottom-right neighbour is the largest address of the four
  assign far_sum  = SUMW'(pixel_index_i) + SUMW'(line_width_i) + SUMW'(1);
  assign far_bad  = 32'(far_sum) >= 32'(STORE_PIXELS);
  assign base_bad = 32'(pixel_index_i) >= 32'(STORE_PIXELS);

  // classify: writes past the store and the unused opcode are dropped
  always_comb begin
    unique case (op)
      OP_WRITE:    keep = !base_bad;
      OP_WEIGHTED: keep = 1'b1;
      OP_BOX:      keep = 1'b1;
      default:     keep = 1'b0;
    endcase
  end

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i && keep;

  always_comb begin
    push_req_o.op     = op;
    push_req_o.base   = pixel_index_i;
    push_req_o.pixel  = {chan_c_i, chan_b_i, chan_a_i};
    push_req_o.weight = weight_i;
    push_req_o.bad    = far_bad;
    push_req_o.last   = last_entry_i;
  end

endmodule

`default_nettype wire

[rtl/core/brm_fifo.sv]
// ----------------------------------------------------------------------------
// brm_fifo: short request queue
// Decouples the front from the back so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module brm_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire brm_pkg::req_t push_req_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output brm_pkg::req_t      head_o
);
  import brm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/brm_back.sv]
// ----------------------------------------------------------------------------
// brm_back: pixel store and interpolation datapath
// Executes queued requests in order: stores pixels, or reads the four
// neighbours one per pass, accumulates weighted channel values and delivers
// the result through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brm_back #(
  parameter int STORE_PIXELS     = brm_pkg::DEF_STORE_PIXELS,
  parameter int WEIGHT_FRAC_BITS = brm_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [brm_pkg::LW_W-1:0]    line_width_i,
  input  wire logic                        three_channel_i,
  input  wire logic                        req_valid_i,
  input  wire brm_pkg::req_t               req_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [brm_pkg::CHAN_W-1:0]       out_a_o,
  output logic [brm_pkg::CHAN_W-1:0]       out_b_o,
  output logic [brm_pkg::CHAN_W-1:0]       out_c_o,
  output logic                             range_error_o,
  output logic                             last_pixel_o
);
  import brm_pkg::*;

  localparam int AW   = $clog2(STORE_PIXELS);
  localparam int SUMW = (AW > IDX_W + 1) ? AW : IDX_W + 1;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (WEIGHT_FRAC_BITS - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [PIXEL_W-1:0] store_q [STORE_PIXELS];
  logic [PIXEL_W-1:0] rdata_q;

  req_t                      cur_q;
  logic [1:0]                nbr_q, nbr_d;
  logic [2:0][PROD_W-1:0]    prod_q;
  logic [2:0][ACC_W-1:0]     acc_q;

  logic                      out_valid_q;
  logic [CHAN_W-1:0]         out_a_q, out_b_q, out_c_q;
  logic                      range_error_q, last_pixel_q;

  logic                      wr_en, rd_en;
  logic [SUMW-1:0]           rd_sum;
  logic [AW-1:0]             rd_addr;
  logic [WEIGHT_W-1:0]       w_sel;
  logic                      slot_free;
  logic                      load_out;
  logic [2:0][CHAN_W-1:0]    res;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = (state_q == ST_IDLE) && req_valid_i;
  assign wr_en     = pop_o && (req_i.op == OP_WRITE);
  assign rd_en     = state_q == ST_READ;
  assign load_out  = (state_q == ST_FIN) && slot_free;

  // neighbour address: bit 0 steps right, bit 1 steps one row down
  assign rd_sum  = SUMW'(cur_q.base) + (nbr_q[1] ? SUMW'(line_width_i) : '0)
                 + SUMW'(nbr_q[0]);
  assign rd_addr = rd_sum[AW-1:0];

  // box mode reuses the multiply-accumulate with unit weights
  assign w_sel = (cur_q.op == OP_BOX) ? WEIGHT_W'(1) : cur_q.weight[nbr_q];

  // sequencer
  always_comb begin
    state_d = state_q;
    nbr_d   = nbr_q;
    unique case (state_q)
      ST_IDLE: begin
        nbr_d = 2'd0;
        if (pop_o && req_i.op != OP_WRITE) begin
          state_d = req_i.bad ? ST_FIN : ST_READ;
        end
      end
      ST_READ: state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC: begin
        nbr_d   = nbr_q + 2'd1;
        state_d = (nbr_q == 2'd3) ? ST_FIN : ST_READ;
      end
      ST_FIN: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nbr_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      nbr_q   <= nbr_d;
    end
  end

  // pixel store, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[AW'(req_i.base)] <= req_i.pixel;
    end
    if (rd_en) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  // multiply then accumulate, one neighbour per pass
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= req_i;
      acc_q <= '0;
    end
    if (state_q == ST_MUL) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= PROD_W'(rdata_q[c*CHAN_W +: CHAN_W]) * PROD_W'(w_sel);
      end
    end
    if (state_q == ST_ACC) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= acc_q[c] + ACC_W'(prod_q[c]);
      end
    end
  end

  // round, shift and clamp per channel; box sums are divided by four and out-of-store requests give zero
  always_comb begin
    logic [ACC_W-1:0] shifted;
    for (int c = 0; c < 3; c++) begin
      shifted = (acc_q[c] + ROUND_HALF) >> WEIGHT_FRAC_BITS;
      if (cur_q.bad) begin
        res[c] = '0;
      end else if (cur_q.op == OP_BOX) begin
        res[c] = acc_q[c][CHAN_W+1:2];
      end else if (shifted > ACC_W'(255)) begin
        res[c] = '1;
      end else begin
        res[c] = shifted[CHAN_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_a_q       <= res[0];
      out_b_q       <= three_channel_i ? res[1] : '0;
      out_c_q       <= three_channel_i ? res[2] : '0;
      range_error_q <= cur_q.bad;
      last_pixel_q  <= cur_q.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_a_o       = out_a_q;
  assign out_b_o       = out_b_q;
  assign out_c_o       = out_c_q;
  assign range_error_o = range_error_q;
  assign last_pixel_o  = last_pixel_q;

endmodule

`default_nettype wire

[rtl/core/bilinear_remap_engine.sv]
// ----------------------------------------------------------------------------
// bilinear_remap_engine: bilinear image remap from an on-chip pixel store
// Top level: configuration registers, request front, queue and datapath back.
// ----------------------------------------------------------------------------
// Write requests (opcode 0) fill the pixel store; remap requests (1 weighted,
// 2 box average) read the neighbours at base, base+1, base+line_width and
// base+line_width+1 and return one output pixel each. Requests execute in
// order, so a remap always sees every write accepted before it. The back,
// with its single-port pixel store, handles one request at a time: a write is
// stored as it is popped; a remap is popped, then read, multiplied and
// accumulated for each of the four neighbours, then rounded and loaded into
// the output register; a remap past the end of the store goes from the pop
// straight to that last step. A two-entry request queue keeps the input
// accepting while the back is busy, and the output register lets the back
// finish a pixel while the previous one is still stalled. The store has no
// reset; reading a pixel never written returns undefined data.
`default_nettype none

module bilinear_remap_engine #(
  parameter int STORE_PIXELS     = brm_pkg::DEF_STORE_PIXELS,
  parameter int WEIGHT_FRAC_BITS = brm_pkg::DEF_WEIGHT_FRAC_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [brm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [brm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input requests
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        opcode_i,
  input  wire logic [brm_pkg::IDX_W-1:0]         pixel_index_i,
  input  wire logic [brm_pkg::CHAN_W-1:0]        chan_a_i,
  input  wire logic [brm_pkg::CHAN_W-1:0]        chan_b_i,
  input  wire logic [brm_pkg::CHAN_W-1:0]        chan_c_i,
  input  wire logic [brm_pkg::WEIGHT_W-1:0]      weight_0_i,
  input  wire logic [brm_pkg::WEIGHT_W-1:0]      weight_1_i,
  input  wire logic [brm_pkg::WEIGHT_W-1:0]      weight_2_i,
  input  wire logic [brm_pkg::WEIGHT_W-1:0]      weight_3_i,
  input  wire logic                              last_entry_i,
  // output pixels
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [brm_pkg::CHAN_W-1:0]             out_a_o,
  output logic [brm_pkg::CHAN_W-1:0]             out_b_o,
  output logic [brm_pkg::CHAN_W-1:0]             out_c_o,
  output logic                                   range_error_o,
  output logic                                   last_pixel_o
);
  import brm_pkg::*;

  logic [LW_W-1:0] line_width_q, line_width_d;
  logic            three_channel_q, three_channel_d;

  logic            push, queue_full, pop, queue_valid;
  req_t            push_req, head_req;

  // configuration registers
  always_comb begin
    line_width_d    = line_width_q;
    three_channel_d = three_channel_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LINE_WIDTH:    line_width_d    = cfg_wdata_i[LW_W-1:0];
        REG_THREE_CHANNEL: three_channel_d = cfg_wdata_i[0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q    <= LINE_WIDTH_RESET;
      three_channel_q <= 1'b0;
    end else begin
      line_width_q    <= line_width_d;
      three_channel_q <= three_channel_d;
    end
  end

  brm_front #(
    .STORE_PIXELS (STORE_PIXELS)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .pixel_index_i (pixel_index_i),
    .chan_a_i      (chan_a_i),
    .chan_b_i      (chan_b_i),
    .chan_c_i      (chan_c_i),
    .weight_i      ({weight_3_i, weight_2_i, weight_1_i, weight_0_i}),
    .last_entry_i  (last_entry_i),
    .line_width_i  (line_width_q),
    .push_o        (push),
    .push_req_o    (push_req),
    .queue_full_i  (queue_full)
  );

  brm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .full_o     (queue_full),
    .pop_i      (pop),
    .valid_o    (queue_valid),
    .head_o     (head_req)
  );

  brm_back #(
    .STORE_PIXELS     (STORE_PIXELS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .line_width_i    (line_width_q),
    .three_channel_i (three_channel_q),
    .req_valid_i     (queue_valid),
    .req_i           (head_req),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_a_o         (out_a_o),
    .out_b_o         (out_b_o),
    .out_c_o         (out_c_o),
    .range_error_o   (range_error_o),
    .last_pixel_o    (last_pixel_o)
  );

endmodule

`default_nettype wire

[rtl/core/brm_checker.sv]
// ----------------------------------------------------------------------------
// brm_checker: port-level assertions of the bilinear remap engine
// Watches the output channel against the configuration and the stall rule.
// ----------------------------------------------------------------------------
`default_nettype none

module brm_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           cfg_we_i,
  input wire logic [brm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [brm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic [brm_pkg::CHAN_W-1:0]     out_a_o,
  input wire logic [brm_pkg::CHAN_W-1:0]     out_b_o,
  input wire logic [brm_pkg::CHAN_W-1:0]     out_c_o,
  input wire logic                           range_error_o,
  input wire logic                           last_pixel_o
);
  import brm_pkg::*;

  // mirror of the channel mode; the user must write it only while the block is idle, the block does not enforce this
  logic three_channel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_channel_q <= 1'b0;
    end else if (cfg_we_i && cfg_index_i == REG_THREE_CHANNEL) begin
      three_channel_q <= cfg_wdata_i[0];
    end
  end

  // a stalled output pixel holds its request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_a_o) && $stable(out_b_o)
      && $stable(out_c_o) && $stable(range_error_o) && $stable(last_pixel_o))
    else $error("output request changed while stalled");

  // out-of-store neighbours give an all-zero pixel
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> out_a_o == '0 && out_b_o == '0 && out_c_o == '0)
    else $error("range error with nonzero pixel");

  // single channel mode leaves the upper channels at zero
  a_single_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !three_channel_q |-> out_b_o == '0 && out_c_o == '0)
    else $error("upper channels nonzero in single channel mode");

endmodule

bind bilinear_remap_engine brm_checker u_brm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_index_i   (cfg_index_i),
  .cfg_wdata_i   (cfg_wdata_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_a_o       (out_a_o),
  .out_b_o       (out_b_o),
  .out_c_o       (out_c_o),
  .range_error_o (range_error_o),
  .last_pixel_o  (last_pixel_o)
);

`default_nettype wire
